@@ rtl/lde_pkg.sv @@
// ----------------------------------------------------------------------------
// lde_pkg: shared types and constants of the light dip event counter
// Widths, reset values, register indexes and the counter result bundle.
// ----------------------------------------------------------------------------
package lde_pkg;

  localparam int unsigned THR_W    = 12;
  localparam int unsigned COUNT_W  = 14;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned NDIGITS  = 4;
  localparam int unsigned USED_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [THR_W-1:0] DROP_RESET = THR_W'(50);
  localparam logic [THR_W-1:0] RISE_RESET = THR_W'(30);

  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(9999);
  localparam logic [COUNT_W-1:0] LIM_THOU  = COUNT_W'(999);
  localparam logic [COUNT_W-1:0] LIM_HUND  = COUNT_W'(99);
  localparam logic [COUNT_W-1:0] LIM_TENS  = COUNT_W'(9);
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(9);

  localparam logic [CFG_IDX_W-1:0] CFG_DROP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RISE = CFG_IDX_W'(1);

  // counter view handed to the result register
  typedef struct packed {
    logic [COUNT_W-1:0]              count;
    logic [NDIGITS-1:0][DIGIT_W-1:0] digits;
    logic [USED_W-1:0]               used;
  } cnt_view_t;

endpackage

@@ rtl/lde_dip_det.sv @@
// ----------------------------------------------------------------------------
// lde_dip_det: dip detector
// Holds the reference level and armed flag, flags a completed dip.
// ----------------------------------------------------------------------------
module lde_dip_det #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  input  logic [lde_pkg::THR_W-1:0]     drop_thr_i,
  input  logic [lde_pkg::THR_W-1:0]     rise_thr_i,
  output logic                          hit_o
);

  localparam int unsigned CW =
    ((SAMPLE_BITS > lde_pkg::THR_W) ? SAMPLE_BITS : lde_pkg::THR_W) + 1;

  logic [SAMPLE_BITS-1:0] ref_q, ref_d;
  logic                   armed_q, armed_d;
  logic [CW-1:0]          s_ext, ref_ext;
  logic                   fell, rose;

  // one extra bit so threshold sums never wrap
  assign s_ext   = CW'(sample_i);
  assign ref_ext = CW'(ref_q);
  assign fell    = ref_ext > (s_ext + CW'(drop_thr_i));
  assign rose    = (ref_ext + CW'(rise_thr_i)) < s_ext;

  always_comb begin
    ref_d   = ref_q;
    armed_d = armed_q;
    hit_o   = 1'b0;
    if (!armed_q) begin
      if (fell) armed_d = 1'b1;
      else      ref_d   = sample_i;
    end else if (fell) begin
      ref_d = sample_i;
    end else if (rose) begin
      armed_d = 1'b0;
      hit_o   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q   <= '0;
      armed_q <= 1'b0;
    end else if (en_i) begin
      ref_q   <= ref_d;
      armed_q <= armed_d;
    end
  end

endmodule

@@ rtl/lde_counter.sv @@
// ----------------------------------------------------------------------------
// lde_counter: event counter
// Binary count modulo 10000 alongside a four digit BCD copy.
// ----------------------------------------------------------------------------
module lde_counter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               hit_i,
  output lde_pkg::cnt_view_t view_o
);

  logic [lde_pkg::COUNT_W-1:0]                      count_q, count_d;
  logic [lde_pkg::NDIGITS-1:0][lde_pkg::DIGIT_W-1:0] dig_q, dig_d;
  logic [lde_pkg::NDIGITS:0]                        carry;

  always_comb begin
    count_d = count_q;
    if (hit_i) begin
      count_d = (count_q == lde_pkg::COUNT_MAX) ? '0 : count_q + 1'b1;
    end
  end

  // ripple carry through the digits; 9999 rolls to 0000
  always_comb begin
    carry[0] = hit_i;
    for (int i = 0; i < lde_pkg::NDIGITS; i++) begin
      dig_d[i]   = dig_q[i];
      carry[i+1] = 1'b0;
      if (carry[i]) begin
        if (dig_q[i] >= lde_pkg::DIGIT_MAX) begin
          dig_d[i]   = '0;
          carry[i+1] = 1'b1;
        end else begin
          dig_d[i] = dig_q[i] + 1'b1;
        end
      end
    end
  end

  always_comb begin
    view_o.count  = count_d;
    view_o.digits = dig_d;
    priority if (count_d > lde_pkg::LIM_THOU) view_o.used = lde_pkg::USED_W'(4);
    else if (count_d > lde_pkg::LIM_HUND)     view_o.used = lde_pkg::USED_W'(3);
    else if (count_d > lde_pkg::LIM_TENS)     view_o.used = lde_pkg::USED_W'(2);
    else                                      view_o.used = lde_pkg::USED_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      dig_q   <= '0;
    end else if (en_i) begin
      count_q <= count_d;
      dig_q   <= dig_d;
    end
  end

endmodule

@@ rtl/light_dip_event_counter.sv @@
// ----------------------------------------------------------------------------
// light_dip_event_counter: light dip event counter top level
// Input register, dip detector, event counter and result register.
// ----------------------------------------------------------------------------
// Takes one light sensor sample per beat and returns one result per sample:
// the event flag, the count modulo 10000, its four BCD digits and the
// number of significant digits. A sample is registered on acceptance and
// its result is registered when the result slot is free or being drained.
// A new sample is accepted every cycle while results are taken; the single
// pass through the compare, increment and digit logic between the input
// register and the result register sets that rate. The config port is
// always ready; write it only while the block is idle.
module light_dip_event_counter #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             sample_valid_i,
  output logic                             sample_ready_o,
  input  logic [SAMPLE_BITS-1:0]           sample_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output logic                             event_res_o,
  output logic [lde_pkg::COUNT_W-1:0]      count_o,
  output logic [lde_pkg::DIGIT_W-1:0]      digit_ones_o,
  output logic [lde_pkg::DIGIT_W-1:0]      digit_tens_o,
  output logic [lde_pkg::DIGIT_W-1:0]      digit_hundreds_o,
  output logic [lde_pkg::DIGIT_W-1:0]      digit_thousands_o,
  output logic [lde_pkg::USED_W-1:0]       digits_used_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lde_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lde_pkg::THR_W-1:0]        cfg_data_i
);

  logic [lde_pkg::THR_W-1:0] drop_q, rise_q;
  logic                      in_vld_q;
  logic [SAMPLE_BITS-1:0]    in_smp_q;
  logic                      adv;
  logic                      hit;
  lde_pkg::cnt_view_t        view;
  logic                      out_vld_q;
  logic                      out_evt_q;
  lde_pkg::cnt_view_t        out_view_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q <= lde_pkg::DROP_RESET;
      rise_q <= lde_pkg::RISE_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_idx_i == lde_pkg::CFG_DROP) drop_q <= cfg_data_i;
      if (cfg_idx_i == lde_pkg::CFG_RISE) rise_q <= cfg_data_i;
    end
  end

  // stage moves when the result slot is free or being drained
  assign adv            = in_vld_q && (!out_vld_q || res_ready_i);
  assign sample_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (sample_ready_o) begin
      in_vld_q <= sample_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_valid_i && sample_ready_o) in_smp_q <= sample_i;
  end

  lde_dip_det #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dip (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .sample_i   (in_smp_q),
    .drop_thr_i (drop_q),
    .rise_thr_i (rise_q),
    .hit_o      (hit)
  );

  lde_counter u_cnt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .hit_i  (hit),
    .view_o (view)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (res_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_evt_q  <= hit;
      out_view_q <= view;
    end
  end

  assign res_valid_o       = out_vld_q;
  assign event_res_o       = out_evt_q;
  assign count_o           = out_view_q.count;
  assign digit_ones_o      = out_view_q.digits[0];
  assign digit_tens_o      = out_view_q.digits[1];
  assign digit_hundreds_o  = out_view_q.digits[2];
  assign digit_thousands_o = out_view_q.digits[3];
  assign digits_used_o     = out_view_q.used;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (count_o <= lde_pkg::COUNT_MAX))
    else $error("count out of range");

  a_zero_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (count_o == '0)) |->
      (digit_ones_o == '0 && digit_tens_o == '0 &&
       digit_hundreds_o == '0 && digit_thousands_o == '0))
    else $error("digits not zero at zero count");

  a_used_thou: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |->
      ((digits_used_o == lde_pkg::USED_W'(4)) == (digit_thousands_o != '0)))
    else $error("digits_used disagrees with thousands digit");
`endif

endmodule
